[rtl/utf8wc_pkg.sv]
package utf8wc_pkg;

    // Default width of the saturating running totals
    localparam int COUNT_WIDTH_DEF = 20;

    // Byte queue: up to three held bytes plus the incoming one
    localparam int Q_DEPTH = 4;
    localparam int CNT_W   = 3;

    // Configuration port
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 20;
    localparam int WEIGHT_W   = 4;
    localparam int LIMIT_W    = 20;

    localparam logic [CFG_ADDR_W-1:0] REG_MULTIBYTE_WEIGHT = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CHAR_LIMIT       = 1'd1;

    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 4'd1;
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 20'hFFFFF;

    // Lead and continuation byte patterns
    localparam logic [7:0] ASCII_MASK = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_CODE = 8'hF0;
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_CODE  = 8'h80;
    localparam logic [7:0] PAYLOAD6   = 8'h3F;
    localparam logic [7:0] PAYLOAD3   = 8'h07;

    localparam logic [20:0] MAX_CODE_POINT = 21'h10FFFF;

    // One decision of the scanner for the current queue contents
    typedef struct packed {
        logic             char_emit;  // settle one character from the queue front
        logic             term;       // emit the terminal result of a zero byte
        logic [2:0]       len;        // bytes reported for the character
        logic             valid;      // well-formed character
        logic [CNT_W-1:0] drop;       // bytes removed from the queue front
    } step_t;

endpackage

[rtl/utf8wc_step.sv]
module utf8wc_step (
    input  logic [utf8wc_pkg::Q_DEPTH-1:0][7:0] q,
    input  logic [utf8wc_pkg::CNT_W-1:0]        cnt,
    input  logic                                flush,
    input  logic                                zero,
    output utf8wc_pkg::step_t                   step
);

    logic [2:0]  lead;
    logic        bad_cont;
    logic        short_seq;
    logic        cp_bad;
    logic [20:0] cp;

    always_comb
    begin
        lead = 3'd0;
        if ((q[0] & utf8wc_pkg::ASCII_MASK) == 8'h00)
        begin
            lead = 3'd1;
        end
        else if ((q[0] & utf8wc_pkg::LEAD2_MASK) == utf8wc_pkg::LEAD2_CODE)
        begin
            lead = 3'd2;
        end
        else if ((q[0] & utf8wc_pkg::LEAD3_MASK) == utf8wc_pkg::LEAD3_CODE)
        begin
            lead = 3'd3;
        end
        else if ((q[0] & utf8wc_pkg::LEAD4_MASK) == utf8wc_pkg::LEAD4_CODE)
        begin
            lead = 3'd4;
        end

        // Check every continuation byte that is both needed and present
        bad_cont = 1'b0;
        for (int i = 1; i < utf8wc_pkg::Q_DEPTH; i++)
        begin
            if ((3'(i) < lead) && (3'(i) < cnt)
                && ((q[i] & utf8wc_pkg::CONT_MASK) != utf8wc_pkg::CONT_CODE))
            begin
                bad_cont = 1'b1;
            end
        end

        short_seq = (cnt < lead);
        cp = {q[0][2:0], q[1][5:0], q[2][5:0], q[3][5:0]};
        cp_bad = (lead == 3'd4) && (cp > utf8wc_pkg::MAX_CODE_POINT);

        step = '0;
        if (cnt != '0)
        begin
            if (lead <= 3'd1)
            begin
                step.char_emit = 1'b1;
                step.len       = 3'd1;
                step.valid     = (lead == 3'd1);
                step.drop      = 3'd1;
            end
            else if (!bad_cont && short_seq && !flush)
            begin
                // hold an incomplete sequence until more bytes arrive
                step.char_emit = 1'b0;
            end
            else if (bad_cont || short_seq || cp_bad)
            begin
                step.char_emit = 1'b1;
                step.len       = 3'd1;
                step.valid     = 1'b0;
                step.drop      = 3'd1;
            end
            else
            begin
                step.char_emit = 1'b1;
                step.len       = lead;
                step.valid     = 1'b1;
                step.drop      = lead;
            end
        end
        else if (zero)
        begin
            step.term = 1'b1;
        end
    end

endmodule

[rtl/utf8wc_tally.sv]
module utf8wc_tally #(
    parameter int COUNT_WIDTH = utf8wc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              upd,
    input  logic                              clr,
    input  logic [2:0]                        len,
    input  logic                              valid,
    input  logic [utf8wc_pkg::WEIGHT_W-1:0]   mb_weight,
    input  logic [utf8wc_pkg::LIMIT_W-1:0]    limit,
    output logic [utf8wc_pkg::WEIGHT_W-1:0]   weight,
    output logic [COUNT_WIDTH-1:0]            total,
    output logic [COUNT_WIDTH-1:0]            kept_bytes,
    output logic                              kept
);

    logic [COUNT_WIDTH-1:0]         total_reg, total_next;
    logic [COUNT_WIDTH-1:0]         kb_reg, kb_next;
    logic [utf8wc_pkg::LIMIT_W-1:0] kw_reg, kw_next;
    logic                           closed_reg, closed_next;

    logic [COUNT_WIDTH:0]           tsum;
    logic [COUNT_WIDTH:0]           bsum;
    logic [utf8wc_pkg::LIMIT_W:0]   ksum;
    logic [COUNT_WIDTH-1:0]         total_new;
    logic [COUNT_WIDTH-1:0]         kb_new;
    logic                           fit;

    always_comb
    begin
        weight = 4'd1;
        if (valid && (len > 3'd1) && (mb_weight > 4'd1))
        begin
            weight = mb_weight;
        end

        tsum      = {1'b0, total_reg} + (COUNT_WIDTH+1)'(weight);
        total_new = tsum[COUNT_WIDTH] ? '1 : tsum[COUNT_WIDTH-1:0];
        bsum      = {1'b0, kb_reg} + (COUNT_WIDTH+1)'(len);
        kb_new    = bsum[COUNT_WIDTH] ? '1 : bsum[COUNT_WIDTH-1:0];
        ksum      = {1'b0, kw_reg} + (utf8wc_pkg::LIMIT_W+1)'(weight);
        fit       = !closed_reg && (ksum <= {1'b0, limit});

        total      = upd ? total_new : total_reg;
        kept_bytes = (upd && fit) ? kb_new : kb_reg;
        kept       = fit;

        total_next  = total_reg;
        kb_next     = kb_reg;
        kw_next     = kw_reg;
        closed_next = closed_reg;
        if (clr)
        begin
            total_next  = '0;
            kb_next     = '0;
            kw_next     = '0;
            closed_next = 1'b0;
        end
        else if (upd)
        begin
            total_next = total_new;
            if (fit)
            begin
                kw_next = ksum[utf8wc_pkg::LIMIT_W-1:0];
                kb_next = kb_new;
            end
            else
            begin
                // the first character that overflows closes the prefix until the next clear
                closed_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg  <= '0;
            kb_reg     <= '0;
            kw_reg     <= '0;
            closed_reg <= 1'b0;
        end
        else
        begin
            total_reg  <= total_next;
            kb_reg     <= kb_next;
            kw_reg     <= kw_next;
            closed_reg <= closed_next;
        end
    end

endmodule

[rtl/utf8_weighted_char_counter.sv]
// Channel   Dir  Handshake               Payload
// s_axis    in   s_axis_tvalid/tready    tdata: byte_value; tlast: end_of_string
// m_axis    out  m_axis_tvalid/tready    tdata: char_bytes, char_weight, total_count,
//                                        kept_bytes; tuser: char_valid, char_kept;
//                                        tlast: last_result
// cfg       in   cfg_we (no wait)        cfg_addr, cfg_wdata
//
// One byte per cycle in the common case: a new byte is taken in the same cycle that
// the previous result is loaded into the output register. A broken sequence settles
// one invalid byte per cycle while the held bytes are rescanned, and the input waits
// meanwhile; a zero byte adds a terminal result of its own.
// Reset clears the queue, totals and string flags; registers return to reset values.
// A stalled output holds the scanner and the input while a result is due.
module utf8_weighted_char_counter #(
    parameter int COUNT_WIDTH = utf8wc_pkg::COUNT_WIDTH_DEF,
    localparam int OUT_W = ((2 * COUNT_WIDTH + 7 + 7) / 8) * 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // byte_value[7:0]
    input  logic [7:0]                          s_axis_tdata,
    input  logic                                s_axis_tlast,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // char_bytes[2:0], char_weight[6:3], total_count, kept_bytes, zero fill
    output logic [OUT_W-1:0]                    m_axis_tdata,
    // char_valid[0], char_kept[1]
    output logic [1:0]                          m_axis_tuser,
    output logic                                m_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic                                cfg_we,
    input  logic [utf8wc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [utf8wc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int PAD_W = OUT_W - 2 * COUNT_WIDTH - 7;

    // Configuration registers
    logic [utf8wc_pkg::WEIGHT_W-1:0] mbw_reg;
    logic [utf8wc_pkg::LIMIT_W-1:0]  limit_reg;

    // Scanner state: byte queue and string flags
    logic [utf8wc_pkg::Q_DEPTH-1:0][7:0] q_reg, q_post, q_next;
    logic [utf8wc_pkg::CNT_W-1:0]        cnt_reg, cnt_post, cnt_next, rem;
    logic flush_reg, flush_post, flush_next;
    logic zero_reg, zero_post, zero_next;
    logic end_reg, end_post, end_next;
    logic aterm_reg, aterm_post, aterm_next;

    // Output register
    logic                            m_valid_reg;
    logic [2:0]                      o_bytes_reg;
    logic [utf8wc_pkg::WEIGHT_W-1:0] o_weight_reg;
    logic [COUNT_WIDTH-1:0]          o_total_reg;
    logic [COUNT_WIDTH-1:0]          o_kb_reg;
    logic                            o_valid_reg;
    logic                            o_kept_reg;
    logic                            o_last_reg;

    utf8wc_pkg::step_t step;
    logic emitting, out_free, go, quiet, accept;
    logic clear_step, clear_acc, last_flag;
    logic [utf8wc_pkg::CNT_W-1:0] sel;

    logic [utf8wc_pkg::WEIGHT_W-1:0] t_weight;
    logic [COUNT_WIDTH-1:0]          t_total;
    logic [COUNT_WIDTH-1:0]          t_kb;
    logic                            t_kept;

    utf8wc_step u_step (
        .q     (q_reg),
        .cnt   (cnt_reg),
        .flush (flush_reg),
        .zero  (zero_reg),
        .step  (step)
    );

    utf8wc_tally #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_tally (
        .clk        (clk),
        .rst_n      (rst_n),
        .upd        (go && step.char_emit),
        .clr        (clear_step || clear_acc),
        .len        (step.len),
        .valid      (step.valid),
        .mb_weight  (mbw_reg),
        .limit      (limit_reg),
        .weight     (t_weight),
        .total      (t_total),
        .kept_bytes (t_kb),
        .kept       (t_kept)
    );

    assign emitting = step.char_emit || step.term;
    assign out_free = !m_valid_reg || m_axis_tready;
    // advance the scanner unless a result is due and the output is still full
    assign go       = !emitting || out_free;
    assign rem      = cnt_reg - step.drop;

    // State after this cycle's scan step
    always_comb
    begin
        q_post     = q_reg;
        cnt_post   = cnt_reg;
        flush_post = flush_reg;
        zero_post  = zero_reg;
        end_post   = end_reg;
        aterm_post = aterm_reg;
        clear_step = 1'b0;
        sel        = '0;

        if (go && step.char_emit)
        begin
            // drop the settled bytes from the queue front
            for (int i = 0; i < utf8wc_pkg::Q_DEPTH; i++)
            begin
                sel = utf8wc_pkg::CNT_W'(i) + step.drop;
                if (sel < utf8wc_pkg::CNT_W'(utf8wc_pkg::Q_DEPTH))
                begin
                    q_post[i] = q_reg[sel[1:0]];
                end
            end
            cnt_post = rem;
            // a flushed string without zero byte ends with its last character
            if (flush_reg && !zero_reg && (rem == '0))
            begin
                clear_step = 1'b1;
            end
        end

        if (go && step.term)
        begin
            zero_post  = 1'b0;
            flush_post = 1'b0;
            if (end_reg)
            begin
                clear_step = 1'b1;
            end
            else
            begin
                aterm_post = 1'b1;
            end
        end

        if (clear_step)
        begin
            cnt_post   = '0;
            flush_post = 1'b0;
            zero_post  = 1'b0;
            end_post   = 1'b0;
            aterm_post = 1'b0;
        end

        // take a new byte only when nothing more is owed from the queue
        quiet = !emitting || ((cnt_post == '0) && !zero_post);
    end

    assign s_axis_tready = go && quiet;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Merge the accepted item into the post-step state
    always_comb
    begin
        q_next     = q_post;
        cnt_next   = cnt_post;
        flush_next = flush_post;
        zero_next  = zero_post;
        end_next   = end_post;
        aterm_next = aterm_post;
        clear_acc  = 1'b0;

        if (accept)
        begin
            if (aterm_post)
            begin
                // ignore bytes after a zero byte; the string's last byte restarts
                if (s_axis_tlast)
                begin
                    clear_acc  = 1'b1;
                    aterm_next = 1'b0;
                end
            end
            else if (s_axis_tdata == 8'h00)
            begin
                flush_next = 1'b1;
                zero_next  = 1'b1;
                end_next   = s_axis_tlast;
            end
            else
            begin
                q_next[cnt_post[1:0]] = s_axis_tdata;
                cnt_next   = cnt_post + utf8wc_pkg::CNT_W'(1);
                flush_next = s_axis_tlast;
                end_next   = s_axis_tlast;
            end
        end
    end

    assign last_flag = step.term
                       || (step.char_emit && flush_reg && !zero_reg && (rem == '0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            flush_reg <= 1'b0;
            zero_reg  <= 1'b0;
            end_reg   <= 1'b0;
            aterm_reg <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            flush_reg <= flush_next;
            zero_reg  <= zero_next;
            end_reg   <= end_next;
            aterm_reg <= aterm_next;
        end
    end

    // Queue bytes carry no reset; the count says which are live
    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mbw_reg   <= utf8wc_pkg::WEIGHT_RESET;
            limit_reg <= utf8wc_pkg::LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                utf8wc_pkg::REG_MULTIBYTE_WEIGHT:
                begin
                    mbw_reg <= cfg_wdata[utf8wc_pkg::WEIGHT_W-1:0];
                end
                utf8wc_pkg::REG_CHAR_LIMIT:
                begin
                    limit_reg <= cfg_wdata[utf8wc_pkg::LIMIT_W-1:0];
                end
                default:
                begin
                    mbw_reg <= mbw_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (go && emitting)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    // Load a result; the terminal result reports the totals with no character
    always_ff @(posedge clk)
    begin
        if (go && emitting)
        begin
            o_bytes_reg  <= step.char_emit ? step.len : 3'd0;
            o_valid_reg  <= step.char_emit && step.valid;
            o_weight_reg <= step.char_emit ? t_weight : '0;
            o_kept_reg   <= step.char_emit && t_kept;
            o_total_reg  <= t_total;
            o_kb_reg     <= t_kb;
            o_last_reg   <= last_flag;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, o_kb_reg, o_total_reg, o_weight_reg, o_bytes_reg};
    assign m_axis_tuser  = {o_kept_reg, o_valid_reg};
    assign m_axis_tlast  = o_last_reg;

endmodule

[tb/utf8wc_char_checker.sv]
`default_nettype none

// Watches the byte and result channels and the register port, predicts every
// settled character and terminal result, and compares the results in order.
module utf8wc_char_checker
    import utf8wc_pkg::*;
#(
    parameter int OUT_W = ((2 * COUNT_WIDTH_DEF + 7 + 7) / 8) * 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [7:0]            s_axis_tdata,
    input  wire logic                  s_axis_tlast,
    input  wire logic                  s_axis_tvalid,
    input  wire logic                  s_axis_tready,
    input  wire logic [OUT_W-1:0]      m_axis_tdata,
    input  wire logic [1:0]            m_axis_tuser,
    input  wire logic                  m_axis_tlast,
    input  wire logic                  m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                         due_n,
    output int                         fail_n
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = COUNT_WIDTH_DEF;
    localparam int unsigned COUNT_MAX = (1 << CW) - 1;

    typedef struct {
        logic [2:0]    nbytes;
        logic          valid;
        logic [3:0]    weight;
        logic [CW-1:0] total;
        logic [CW-1:0] kept_bytes;
        logic          kept;
        logic          last;
    } char_rec_t;

    char_rec_t due_chars[$];
    char_rec_t step_chars[$];
    logic [7:0] scan_q[$];

    // Register copies
    logic [WEIGHT_W-1:0] mb_weight = WEIGHT_RESET;
    logic [LIMIT_W-1:0]  char_lim  = LIMIT_RESET;

    // String state
    logic [7:0]  held[3];
    int          held_n    = 0;
    int unsigned wsum      = 0;
    int unsigned kept_w    = 0;
    int unsigned kept_b    = 0;
    bit          closed    = 1'b0;
    bit          in_tail   = 1'b0;

    task automatic flag_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
        // keep the log readable if something breaks badly
        if (fail_n < 100)
            $display("%0t ns: %s got 0x%0h want 0x%0h", $time, what, got, want);
        fail_n++;
    endtask

    function automatic int lead_len(input logic [7:0] b);
        if ((b & ASCII_MASK) == 8'h00)
            return 1;
        if ((b & LEAD2_MASK) == LEAD2_CODE)
            return 2;
        if ((b & LEAD3_MASK) == LEAD3_CODE)
            return 3;
        if ((b & LEAD4_MASK) == LEAD4_CODE)
            return 4;
        return 0;
    endfunction

    task automatic clear_string();
        held_n  = 0;
        wsum    = 0;
        kept_w  = 0;
        kept_b  = 0;
        closed  = 1'b0;
        in_tail = 1'b0;
    endtask

    // Settle one character: weight it, advance the totals, decide if it is kept.
    task automatic settle(input int len, input bit ok);
        char_rec_t   r;
        int unsigned w;
        w = (ok && len > 1 && mb_weight > 1) ? int'(mb_weight) : 1;
        wsum = (wsum + w > COUNT_MAX) ? COUNT_MAX : wsum + w;
        r.kept = 1'b0;
        if (!closed && kept_w + w <= char_lim)
        begin
            kept_w += w;
            kept_b = (kept_b + len > COUNT_MAX) ? COUNT_MAX : kept_b + len;
            r.kept = 1'b1;
        end
        else
            closed = 1'b1;
        r.nbytes     = len[2:0];
        r.valid      = ok;
        r.weight     = w[3:0];
        r.total      = wsum[CW-1:0];
        r.kept_bytes = kept_b[CW-1:0];
        r.last       = 1'b0;
        step_chars.insert(step_chars.size(), r);
    endtask

    // Settle characters from the scan queue; without flush an incomplete but
    // well-formed sequence stays held.
    task automatic scan_bytes(input bit flush);
        int         len;
        int         span;
        bit         bad;
        logic [20:0] cp;
        while (scan_q.size() > 0)
        begin
            len = lead_len(scan_q[0]);
            if (len <= 1)
            begin
                settle(1, len == 1);
                void'(scan_q.pop_front());
                continue;
            end
            span = (scan_q.size() < len) ? scan_q.size() : len;
            bad = 1'b0;
            for (int i = 1; i < span; i++)
                if ((scan_q[i] & CONT_MASK) != CONT_CODE)
                    bad = 1'b1;
            if (!bad && scan_q.size() < len)
            begin
                if (!flush)
                    break;
                bad = 1'b1;
            end
            if (!bad && len == 4)
            begin
                cp = {scan_q[0][2:0], scan_q[1][5:0], scan_q[2][5:0], scan_q[3][5:0]};
                if (cp > MAX_CODE_POINT)
                    bad = 1'b1;
            end
            if (bad)
            begin
                settle(1, 1'b0);
                void'(scan_q.pop_front());
            end
            else
            begin
                settle(len, 1'b1);
                repeat (len) void'(scan_q.pop_front());
            end
        end
    endtask

    task automatic take_byte(input logic [7:0] b, input bit eos);
        char_rec_t r;
        step_chars.delete();
        if (in_tail)
        begin
            // bytes after a terminator are dropped until the end flag
            if (eos)
                clear_string();
            return;
        end
        scan_q.delete();
        for (int i = 0; i < held_n; i++)
            scan_q.insert(scan_q.size(), held[i]);
        if (b == 8'h00)
        begin
            scan_bytes(1'b1);
            r.nbytes     = 3'd0;
            r.valid      = 1'b0;
            r.weight     = 4'd0;
            r.total      = wsum[CW-1:0];
            r.kept_bytes = kept_b[CW-1:0];
            r.kept       = 1'b0;
            r.last       = 1'b1;
            step_chars.insert(step_chars.size(), r);
            if (eos)
                clear_string();
            else
            begin
                held_n  = 0;
                in_tail = 1'b1;
            end
        end
        else
        begin
            scan_q.insert(scan_q.size(), b);
            scan_bytes(eos);
            if (eos)
            begin
                if (step_chars.size() > 0)
                    step_chars[step_chars.size() - 1].last = 1'b1;
                clear_string();
            end
            else
            begin
                held_n = scan_q.size();
                for (int i = 0; i < held_n; i++)
                    held[i] = scan_q[i];
            end
        end
        foreach (step_chars[i])
            due_chars.insert(due_chars.size(), step_chars[i]);
    endtask

    always @(posedge clk)
    begin
        char_rec_t got;
        char_rec_t want;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_addr == REG_MULTIBYTE_WEIGHT)
                    mb_weight = cfg_wdata[WEIGHT_W-1:0];
                else if (cfg_addr == REG_CHAR_LIMIT)
                    char_lim = cfg_wdata[LIMIT_W-1:0];
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.nbytes     = m_axis_tdata[2:0];
                got.weight     = m_axis_tdata[6:3];
                got.total      = m_axis_tdata[7 +: CW];
                got.kept_bytes = m_axis_tdata[7 + CW +: CW];
                got.valid      = m_axis_tuser[0];
                got.kept       = m_axis_tuser[1];
                got.last       = m_axis_tlast;
                if (due_chars.size() == 0)
                    flag_mismatch("result with nothing due, char_bytes", got.nbytes, 0);
                else
                begin
                    want = due_chars.pop_front();
                    if (got.nbytes != want.nbytes)
                        flag_mismatch("char_bytes", got.nbytes, want.nbytes);
                    if (got.valid != want.valid)
                        flag_mismatch("char_valid", got.valid, want.valid);
                    if (got.weight != want.weight)
                        flag_mismatch("char_weight", got.weight, want.weight);
                    if (got.total != want.total)
                        flag_mismatch("total_count", got.total, want.total);
                    if (got.kept_bytes != want.kept_bytes)
                        flag_mismatch("kept_bytes", got.kept_bytes, want.kept_bytes);
                    if (got.kept != want.kept)
                        flag_mismatch("char_kept", got.kept, want.kept);
                    if (got.last != want.last)
                        flag_mismatch("last_result", got.last, want.last);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                take_byte(s_axis_tdata, s_axis_tlast);
            due_n = due_chars.size();
        end
    end

endmodule

`default_nettype wire

[tb/tb_utf8_weighted_char_counter.sv]
`default_nettype none

// Top of the bench: clock, reset, byte stimulus, result back-pressure and
// the verdict. All prediction and comparison lives in the checker.
module tb_utf8_weighted_char_counter;
    timeunit 1ns;
    timeprecision 1ps;

    import utf8wc_pkg::*;

    localparam int OUT_W       = ((2 * COUNT_WIDTH_DEF + 7 + 7) / 8) * 8;
    localparam int RANDOM_GOAL = 300;   // counted items over the random phases
    localparam int HOLD_CYCLES = 120;   // long receiver hold-off
    localparam int SETTLE_CYC  = 8;     // covers a rescan of held bytes plus a terminal

    // Kinds of character the random strings are built from
    typedef enum int {
        CH_ASCII,
        CH_TWO,
        CH_THREE,
        CH_FOUR,
        CH_ABOVE,   // four-byte form above the last code point
        CH_BROKEN,  // lead cut short by a non-continuation byte
        CH_STRAY    // lone continuation or a never-valid lead
    } char_kind_t;

    // Receiver ready patterns
    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_DENSE
    } rx_mode_t;

    logic clk = 1'b0;
    logic rst_n;

    logic [7:0]            s_axis_tdata;
    logic                  s_axis_tlast;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [OUT_W-1:0]      m_axis_tdata;
    logic [1:0]            m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int due_n;
    int fail_n;

    // Sender state; hold_req is shared with the receiver process
    bit hold_req  = 1'b0;
    int burst_left = 0;
    int fed_n      = 0;   // items that the block had to scan

    logic [7:0] text_q[$];

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    utf8_weighted_char_counter u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    utf8wc_char_checker #(.OUT_W(OUT_W)) u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .due_n         (due_n),
        .fail_n        (fail_n)
    );

    // Random byte in [lo, hi]
    function automatic logic [7:0] pick(input int lo, input int hi);
        logic [7:0] v;
        v = 8'($urandom_range(hi, lo));
        return v;
    endfunction

    function automatic logic [7:0] cont_byte();
        return pick(8'h80, 8'hBF);
    endfunction

    // Lead byte that asks for n bytes in total (4 includes the F5..F7 leads)
    function automatic logic [7:0] lead_byte(input int n);
        if (n == 2)
            return pick(8'hC0, 8'hDF);
        if (n == 3)
            return pick(8'hE0, 8'hEF);
        return pick(8'hF0, 8'hF7);
    endfunction

    function automatic char_kind_t pick_kind();
        int r;
        r = $urandom_range(99, 0);
        if (r < 30)
            return CH_ASCII;
        if (r < 45)
            return CH_TWO;
        if (r < 60)
            return CH_THREE;
        if (r < 75)
            return CH_FOUR;
        if (r < 80)
            return CH_ABOVE;
        if (r < 90)
            return CH_BROKEN;
        return CH_STRAY;
    endfunction

    // Append one byte to the text.
    task automatic add_byte(input logic [7:0] b);
        text_q.insert(text_q.size(), b);
    endtask

    // Append the bytes of one character of the given kind to the text.
    task automatic add_char(input char_kind_t k);
        int n;
        case (k)
            CH_ASCII:
                add_byte(pick(8'h01, 8'h7F));
            CH_TWO:
            begin
                add_byte(pick(8'hC0, 8'hDF));
                add_byte(cont_byte());
            end
            CH_THREE:
            begin
                add_byte(pick(8'hE0, 8'hEF));
                repeat (2) add_byte(cont_byte());
            end
            CH_FOUR:
            begin
                // stay at or below the last code point
                if ($urandom_range(3, 0) == 0)
                begin
                    add_byte(8'hF4);
                    add_byte(pick(8'h80, 8'h8F));
                end
                else
                begin
                    add_byte(pick(8'hF0, 8'hF3));
                    add_byte(cont_byte());
                end
                repeat (2) add_byte(cont_byte());
            end
            CH_ABOVE:
            begin
                if ($urandom_range(1, 0) == 0)
                begin
                    add_byte(8'hF4);
                    add_byte(pick(8'h90, 8'hBF));
                end
                else
                begin
                    add_byte(pick(8'hF5, 8'hF7));
                    add_byte(cont_byte());
                end
                repeat (2) add_byte(cont_byte());
            end
            CH_BROKEN:
            begin
                n = $urandom_range(4, 2);
                add_byte(lead_byte(n));
                repeat ($urandom_range(n - 2, 0)) add_byte(cont_byte());
                // break it with ASCII or with a byte from C0 to FF
                if ($urandom_range(1, 0) == 0)
                    add_byte(pick(8'h01, 8'h7F));
                else
                    add_byte(pick(8'hC0, 8'hFF));
            end
            default:
            begin
                if ($urandom_range(1, 0) == 0)
                    add_byte(cont_byte());
                else
                    add_byte(pick(8'hF8, 8'hFF));
            end
        endcase
    endtask

    // Well-formed so far but incomplete: flushed as invalid bytes when the string ends.
    task automatic add_partial();
        int n;
        n = $urandom_range(4, 2);
        add_byte(lead_byte(n));
        repeat ($urandom_range(n - 2, 0)) add_byte(cont_byte());
    endtask

    // Offer one item and hold it until the block takes it. Bursts of random
    // length are broken up by random gaps.
    task automatic send_byte(input logic [7:0] b, input logic eos);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(6, 1);
            repeat (gap)
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
            end
            burst_left = $urandom_range(30, 1);
        end
        burst_left--;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eos;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Send the text; raise the end flag on its last byte if asked.
    task automatic send_text(input bit eos);
        foreach (text_q[i])
        begin
            send_byte(text_q[i], eos && (i == text_q.size() - 1));
            fed_n++;
        end
    endtask

    // Drop valid, wait out every due result, then let the scanner settle.
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (due_n != 0)
            @(negedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    // Write both registers on back-to-back cycles; only while idle.
    task automatic set_regs(input logic [WEIGHT_W-1:0] weight, input logic [LIMIT_W-1:0] limit);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_MULTIBYTE_WEIGHT;
        cfg_wdata <= CFG_DATA_W'(weight);
        @(negedge clk);
        cfg_addr  <= REG_CHAR_LIMIT;
        cfg_wdata <= CFG_DATA_W'(limit);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // One whole random string, closed by the end flag, by a zero byte with
    // the end flag, or by a zero byte followed by ignored junk.
    task automatic random_string();
        int nch;
        int ending;
        text_q.delete();
        nch = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 20) : $urandom_range(10, 0);
        repeat (nch) add_char(pick_kind());
        if ($urandom_range(5, 0) == 0)
            add_partial();
        ending = $urandom_range(99, 0);
        if (ending < 45)
        begin
            if (text_q.size() == 0)
                add_char(CH_ASCII);
            send_text(1'b1);
        end
        else
        begin
            add_byte(8'h00);
            if (ending < 65)
                send_text(1'b1);
            else
            begin
                send_text(1'b0);
                // junk after the terminator is ignored, so it is not counted
                repeat ($urandom_range(3, 0)) send_byte(pick(8'h00, 8'hFF), 1'b0);
                send_byte(pick(8'h00, 8'hFF), 1'b1);
            end
        end
    endtask

    // Hard stop in case the block hangs
    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Receiver: random ready patterns and one long hold-off that backs the
    // block up into its input.
    initial
    begin : rx_side
        rx_mode_t mode;
        int       left;
        mode = RX_OPEN;
        left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if (left == 0)
                begin
                    mode = rx_mode_t'($urandom_range(3, 0));
                    left = $urandom_range(40, 5);
                end
                left--;
                case (mode)
                    RX_OPEN:   m_axis_tready <= 1'b1;
                    RX_COIN:   m_axis_tready <= 1'($urandom_range(1, 0));
                    RX_SPARSE: m_axis_tready <= ($urandom_range(3, 0) == 0);
                    default:   m_axis_tready <= ($urandom_range(3, 0) != 0);
                endcase
            end
        end
    end

    initial
    begin : stim
        int goal;
        bit hold_done;
        hold_done = 1'b0;

        // Known values on every input from time zero
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = REG_MULTIBYTE_WEIGHT;
        cfg_wdata     = '0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset registers: ASCII, two-, three-byte chars, a never-valid lead,
        // then held bytes flushed by a zero byte, junk after it, and the end
        // flag on ignored junk to open a new string.
        text_q = '{8'h7F, 8'hC2, 8'h80, 8'hE2, 8'h82, 8'hAC, 8'hFF, 8'hE2, 8'h82, 8'h00};
        send_text(1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h80, 1'b1);
        drain();

        // Weight 3, limit 7: the kept prefix closes partway. Cover the last
        // valid code point, one just above it, a lead broken by ASCII, and a
        // sequence cut short by the end flag.
        set_regs(4'd3, 20'd7);
        text_q = '{8'hF0, 8'h9F, 8'h98, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF,
                   8'hC3, 8'h41, 8'hF4, 8'h90, 8'h80, 8'h80, 8'hF0, 8'h9F};
        send_text(1'b1);
        drain();

        // Random phases, each under its own register setting
        for (int p = 0; p < 5; p++)
        begin
            case (p)
                0: set_regs(4'd0, 20'd0);
                1: set_regs(4'd15, 20'hFFFFF);
                2: set_regs(4'd2, 20'd1);
                3: set_regs(4'd1, LIMIT_W'($urandom()));
                default: set_regs(WEIGHT_W'($urandom()), LIMIT_W'($urandom_range(80, 8)));
            endcase
            goal = fed_n + RANDOM_GOAL / 5;
            while (fed_n < goal)
            begin
                // once, stall the receiver long enough to back the block up
                if (p == 2 && !hold_done && fed_n > goal - RANDOM_GOAL / 10)
                begin
                    hold_req  = 1'b1;
                    hold_done = 1'b1;
                end
                random_string();
            end
            drain();
        end

        if (fail_n == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
rtl/utf8wc_pkg.sv
rtl/utf8wc_step.sv
rtl/utf8wc_tally.sv
rtl/utf8_weighted_char_counter.sv
tb/utf8wc_char_checker.sv
tb/tb_utf8_weighted_char_counter.sv
